### rtl/core/idq_pkg.sv
package idq_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CAP_W  = 5;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        ACT_INSERT    = 2'd0,
        ACT_DEL_FRONT = 2'd1,
        ACT_DEL_REAR  = 2'd2,
        ACT_TRAVERSE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_RSVD      = 2'd3
    } t_status;

endpackage

### rtl/core/idq_ram.sv
module idq_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/input_restricted_deque.sv
// Channel   Direction  tdata            tuser           tlast
// s_axis    in         value[31:0]      action[1:0]     -
// m_axis    out        data[31:0]       status[1:0]     last
// cfg       in         i_cfg_wdata = capacity[4:0], written when i_cfg_wen is high
//
// Insert and failed requests: the result is registered in the output register in the cycle after acceptance.
// Delete: one read of the slot memory; the result passes the memory read register, then the output register.
// Traverse: each held entry takes a memory read, then the output register; the next read waits for a free output.
// A new request is taken only when the previous one is done and the output is free.
// i_rst_n is synchronous; reset empties the queue and sets capacity to 16.
// A stalled m_axis holds the result and the traverse walk.
module input_restricted_deque
    import idq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wen,
    input  logic [CAP_W-1:0]  i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]        s_axis_tuser,   // [1:0] action
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [31:0] data
    output logic [1:0]        m_axis_tuser,   // [1:0] status
    output logic              m_axis_tlast
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_TRAV = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cap, n_cap;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_occ, n_occ;
    logic [IDX_W-1:0]  r_walk, n_walk;
    logic [CNT_W-1:0]  r_left, n_left;
    logic              r_rd_last, n_rd_last;
    logic              r_out_valid, n_out_valid;
    logic [DATA_W-1:0] r_out_data, n_out_data;
    t_status           r_out_status, n_out_status;
    logic              r_out_last, n_out_last;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic [DATA_W-1:0] mem_rdata;
    logic              out_free;
    logic              accept;
    t_action           act;

    function automatic logic [IDX_W-1:0] idx_inc(logic [IDX_W-1:0] idx,
                                                  logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] nxt;
        nxt = {1'b0, idx} + CNT_W'(1);
        return (nxt == cap) ? '0 : nxt[IDX_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] cap_sat(logic [CAP_W-1:0] w);
        if (w == '0) begin
            return CNT_W'(1);
        end else if (int'(w) > DEPTH) begin
            return CNT_W'(DEPTH);
        end
        return CNT_W'(w);
    endfunction

    idq_ram #(
        .DATA_W (DATA_W),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (s_axis_tdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign out_free      = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign act           = t_action'(s_axis_tuser);

    always_comb begin
        n_state      = r_state;
        n_cap        = r_cap;
        n_head       = r_head;
        n_tail       = r_tail;
        n_occ        = r_occ;
        n_walk       = r_walk;
        n_left       = r_left;
        n_rd_last    = r_rd_last;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_re       = 1'b0;
        mem_raddr    = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_out_data = '0;
                    n_out_last = 1'b1;
                    if (act == ACT_INSERT) begin
                        n_out_valid = 1'b1;
                        if (r_occ >= r_cap) begin
                            n_out_status = ST_OVERFLOW;
                        end else begin
                            n_out_status = ST_OK;
                            mem_we       = 1'b1;
                            n_occ        = r_occ + CNT_W'(1);
                            if (r_occ == '0) begin
                                n_head    = '0;
                                n_tail    = '0;
                                mem_waddr = '0;
                            end else begin
                                n_tail    = idx_inc(r_tail, r_cap);
                                mem_waddr = n_tail;
                            end
                        end
                    end else if (r_occ == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_UNDERFLOW;
                    end else begin
                        mem_re    = 1'b1;
                        n_state   = S_READ;
                        n_rd_last = 1'b1;
                        unique case (act)
                            ACT_DEL_FRONT: begin
                                mem_raddr = r_head;
                                n_head    = idx_inc(r_head, r_cap);
                                n_occ     = r_occ - CNT_W'(1);
                            end
                            ACT_DEL_REAR: begin
                                mem_raddr = r_tail;
                                n_tail    = (r_tail == '0) ? IDX_W'(r_cap - CNT_W'(1))
                                                           : r_tail - IDX_W'(1);
                                n_occ     = r_occ - CNT_W'(1);
                            end
                            default: begin
                                mem_raddr = r_head;
                                n_walk    = idx_inc(r_head, r_cap);
                                n_left    = r_occ - CNT_W'(1);
                                n_rd_last = (r_occ == CNT_W'(1));
                            end
                        endcase
                    end
                end
            end
            S_READ: begin
                n_out_valid  = 1'b1;
                n_out_data   = mem_rdata;
                n_out_status = ST_OK;
                n_out_last   = r_rd_last;
                n_state      = r_rd_last ? S_IDLE : S_TRAV;
            end
            S_TRAV: begin
                if (out_free) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_walk;
                    n_walk    = idx_inc(r_walk, r_cap);
                    n_left    = r_left - CNT_W'(1);
                    n_rd_last = (r_left == CNT_W'(1));
                    n_state   = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_wen) begin
            n_cap  = cap_sat(i_cfg_wdata);
            n_head = '0;
            n_tail = '0;
            n_occ  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cap       <= CNT_W'(DEPTH);
            r_head      <= '0;
            r_tail      <= '0;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cap       <= n_cap;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_occ       <= n_occ;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk       <= n_walk;
        r_left       <= n_left;
        r_rd_last    <= n_rd_last;
        r_out_data   <= n_out_data;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

endmodule

### rtl/core/idq_checker.sv
module idq_checker
    import idq_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_wen,
    input logic              s_axis_tvalid,
    input logic              s_axis_tready,
    input logic [1:0]        s_axis_tuser,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [DATA_W-1:0] m_axis_tdata,
    input logic [1:0]        m_axis_tuser,
    input logic              m_axis_tlast
);

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result request right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result request changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != ST_RSVD)
        else $error("reserved status code");

    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0 && m_axis_tlast)
        else $error("error result must carry zero data and last");

    a_insert_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == ACT_INSERT && !i_cfg_wen |=>
            m_axis_tvalid && m_axis_tlast && m_axis_tdata == '0
            && (m_axis_tuser == ST_OK || m_axis_tuser == ST_OVERFLOW))
        else $error("insert request did not give its result next cycle");

endmodule

bind input_restricted_deque idq_checker u_idq_checker (.*);

### test/deque_checker.sv
`timescale 1ns / 100ps

module deque_checker
    import idq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wen,
    input  logic [CAP_W-1:0]  i_cfg_wdata,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]        s_axis_tuser,   // [1:0] action
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [DATA_W-1:0] m_axis_tdata,   // [31:0] data
    input  logic [1:0]        m_axis_tuser,   // [1:0] status
    input  logic              m_axis_tlast,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_result_count
);

    typedef struct packed {
        logic [DATA_W-1:0] data;
        t_status           status;
        logic              last;
    } t_deque_result;

    t_deque_result     due_results[$];
    logic [DATA_W-1:0] slots [DEPTH];
    int                head_idx;
    int                tail_idx;
    int                occupancy;
    int                capacity;

    initial begin
        o_fail_count   = 0;
        o_pending      = 0;
        o_result_count = 0;
        head_idx       = 0;
        tail_idx       = 0;
        occupancy      = 0;
        capacity       = DEPTH;
    end

    function automatic int slots_in_use();
        if (capacity == 0) return 1;
        if (capacity > DEPTH) return DEPTH;
        return capacity;
    endfunction

    task automatic push_result(input logic [DATA_W-1:0] data, input t_status status,
                               input logic last);
        t_deque_result r;
        r.data   = data;
        r.status = status;
        r.last   = last;
        due_results.push_back(r);
    endtask

    task automatic model_deque_request(input t_action act, input logic [DATA_W-1:0] value);
        int cap;
        int idx;
        int k;
        cap = slots_in_use();
        if (act == ACT_INSERT) begin
            if (occupancy >= cap) begin
                push_result('0, ST_OVERFLOW, 1'b1);
            end else begin
                if (occupancy == 0) begin
                    head_idx = 0;
                    tail_idx = 0;
                end else begin
                    tail_idx = (tail_idx + 1) % cap;
                end
                slots[tail_idx] = value;
                occupancy++;
                push_result('0, ST_OK, 1'b1);
            end
        end else if (occupancy == 0) begin
            push_result('0, ST_UNDERFLOW, 1'b1);
        end else begin
            case (act)
                ACT_DEL_FRONT: begin
                    push_result(slots[head_idx], ST_OK, 1'b1);
                    head_idx = (head_idx + 1) % cap;
                    occupancy--;
                end
                ACT_DEL_REAR: begin
                    push_result(slots[tail_idx], ST_OK, 1'b1);
                    tail_idx = (tail_idx == 0) ? cap - 1 : tail_idx - 1;
                    occupancy--;
                end
                default: begin
                    idx = head_idx;
                    for (k = 0; k < occupancy; k++) begin
                        push_result(slots[idx], ST_OK, (k + 1 == occupancy));
                        idx = (idx + 1) % cap;
                    end
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_deque_result exp_r;
        if (!i_rst_n) begin
            head_idx  = 0;
            tail_idx  = 0;
            occupancy = 0;
            capacity  = DEPTH;
            due_results.delete();
        end else begin
            if (i_cfg_wen) begin
                capacity  = int'(i_cfg_wdata);
                head_idx  = 0;
                tail_idx  = 0;
                occupancy = 0;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                model_deque_request(t_action'(s_axis_tuser), s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result data=%h status=%0d last=%b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = due_results.pop_front();
                    o_result_count <= o_result_count + 1;
                    if (m_axis_tdata !== exp_r.data || m_axis_tuser !== exp_r.status ||
                        m_axis_tlast !== exp_r.last) begin
                        $display("%0t: mismatch expected data=%h status=%0d last=%b",
                                 $time, exp_r.data, exp_r.status, exp_r.last);
                        $display("%0t:          actual   data=%h status=%0d last=%b",
                                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= due_results.size();
    end

endmodule

### test/input_restricted_deque_tb.sv
`timescale 1ns / 100ps

module input_restricted_deque_tb;
    import idq_pkg::*;

    localparam int LIMIT = 400000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_wen;
    logic [CAP_W-1:0]  i_cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata;   // [31:0] value
    logic [1:0]        s_axis_tuser;   // [1:0] action
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;   // [31:0] data
    logic [1:0]        m_axis_tuser;   // [1:0] status
    logic              m_axis_tlast;

    int fail_count;
    int pending;
    int result_count;
    int cycle_count = 0;
    int sent_count  = 0;
    int idle_pct    = 0;
    int stall_pct   = 0;

    int phase_cap   [6] = '{16, 3, 1, 31, 5, 7};
    int phase_idle  [6] = '{0, 87, 0, 20, 0, 0};
    int phase_stall [6] = '{0, 0, 87, 20, 0, 0};
    int phase_items [6] = '{70, 70, 60, 80, 70, 70};

    input_restricted_deque DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    deque_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wen      (i_cfg_wen),
        .i_cfg_wdata    (i_cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic send_request(input t_action act, input logic [DATA_W-1:0] value);
        logic idle;
        idle = ($urandom_range(99) < idle_pct);
        while (idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            idle = ($urandom_range(99) < idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sent_count++;
    endtask

    // drain all outstanding results, then pause with the sender idle
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        settle();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        if ($urandom_range(7) == 0) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // alternate fill-heavy and drain-heavy stretches so full, empty and wrap all occur
    function automatic t_action pick_action(input int n);
        int r;
        r = $urandom_range(99);
        if ((n / 16) % 2 == 0) begin
            if (r < 65) return ACT_INSERT;
            if (r < 78) return ACT_DEL_FRONT;
            if (r < 90) return ACT_DEL_REAR;
            return ACT_TRAVERSE;
        end
        if (r < 25) return ACT_INSERT;
        if (r < 55) return ACT_DEL_FRONT;
        if (r < 85) return ACT_DEL_REAR;
        return ACT_TRAVERSE;
    endfunction

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wen     <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_INSERT;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue after reset, default capacity
        send_request(ACT_DEL_FRONT, 32'h1234_5678);
        send_request(ACT_DEL_REAR, 32'h0);
        send_request(ACT_TRAVERSE, 32'h0);
        send_request(ACT_INSERT, 32'h7FFF_FFFF);
        send_request(ACT_INSERT, 32'h8000_0000);
        send_request(ACT_INSERT, 32'h0000_0000);
        send_request(ACT_INSERT, 32'hFFFF_FFFF);
        send_request(ACT_TRAVERSE, 32'hDEAD_BEEF);
        send_request(ACT_DEL_REAR, 32'h0);
        send_request(ACT_DEL_FRONT, 32'h0);

        // capacity 2: overflow, rear wrap on insert and on delete, underflow
        set_capacity(5'd2);
        send_request(ACT_INSERT, 32'd11);
        send_request(ACT_INSERT, 32'd22);
        send_request(ACT_INSERT, 32'd33);
        send_request(ACT_TRAVERSE, 32'h0);
        send_request(ACT_DEL_FRONT, 32'h0);
        send_request(ACT_INSERT, 32'd44);
        send_request(ACT_TRAVERSE, 32'h0);
        send_request(ACT_DEL_REAR, 32'h0);
        send_request(ACT_DEL_REAR, 32'h0);
        send_request(ACT_DEL_REAR, 32'h0);

        // capacity zero acts as one slot
        set_capacity(5'd0);
        send_request(ACT_INSERT, 32'hA5A5_A5A5);
        send_request(ACT_INSERT, 32'h5A5A_5A5A);
        send_request(ACT_TRAVERSE, 32'h0);
        send_request(ACT_DEL_REAR, 32'h0);

        for (int p = 0; p < 6; p++) begin
            set_capacity(CAP_W'(phase_cap[p]));
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            for (int n = 0; n < phase_items[p]; n++) begin
                send_request(pick_action(n), pick_value());
            end
        end

        idle_pct  = 0;
        stall_pct = 0;
        settle();
        repeat (16) @(posedge i_clk);

        $display("Sent %0d requests (insert, both deletes, traverse) at capacities 0 to 31,",
                 sent_count);
        $display("with sender gaps and receiver stalls; %0d results checked", result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
